// ===== design/tar_ext_pkg.sv =====
`default_nettype none
package tar_ext_pkg;

	localparam int HDR_FILL_W = 9;
	localparam int SIZE_W = 36;
	localparam int NAME_WORDS = 7;
	localparam int NAME_BYTES = NAME_WORDS * 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int NAME_LEN_W = 6;
	localparam int M_TDATA_W = 16;

	localparam logic [HDR_FILL_W-1:0] BLOCK_LAST = 9'd511;
	localparam logic [HDR_FILL_W-1:0] NAME_FIELD_BYTES = 9'd100;
	localparam logic [HDR_FILL_W-1:0] SIZE_OFFSET = 9'd124;
	localparam logic [HDR_FILL_W-1:0] TYPE_OFFSET = 9'd156;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_SEVEN = 8'h37;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	localparam logic [CFG_INDEX_W-1:0] REG_NAME_LENGTH = 3'd7;

	typedef enum logic [1:0] {
		PHASE_SPACES = 2'd0,
		PHASE_DIGITS = 2'd1,
		PHASE_DONE   = 2'd2
	} size_phase_t;

	typedef enum logic [1:0] {
		STATUS_NONE      = 2'd0,
		STATUS_COMPLETE  = 2'd1,
		STATUS_NOT_FOUND = 2'd2,
		STATUS_TRUNCATED = 2'd3
	} status_t;

endpackage
`default_nettype wire

// ===== design/tar_entry_extractor_core.sv =====
// The result of an input transfer is registered and appears on the master side in the cycle after the transfer.
// Throughput: one byte per cycle; the header scan, size decode and data count
// all update from a single registered state per byte, and the output register
// takes a new result whenever it is empty or being drained.
// Reset: arst_n clears the scan state, the wanted name and the output valid.
`default_nettype none
module tar_entry_extractor_core #(
	parameter int MAX_NAME_BYTES = 56,
	parameter int SIZE_DIGITS = 12
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tar_ext_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tar_ext_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [7:0]                          s_tdata,  // [7:0] data_byte
	input  wire logic                                s_tuser,  // [0] end_of_input
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// [7:0] payload_byte, [8] archive_ended, [10:9] final_status, rest zero
	output logic [tar_ext_pkg::M_TDATA_W-1:0]        m_tdata,
	output logic                                     m_tuser,  // [0] payload_valid
	output logic                                     m_tlast   // payload_last
);
	import tar_ext_pkg::*;

	localparam logic [HDR_FILL_W-1:0] SIZE_END = HDR_FILL_W'(SIZE_OFFSET + SIZE_DIGITS);
	localparam logic [NAME_LEN_W:0] MAX_NAME = (NAME_LEN_W+1)'(MAX_NAME_BYTES);

	logic [7:0]            name_byte_q [NAME_BYTES];
	logic [NAME_LEN_W-1:0] name_length_q;

	logic [HDR_FILL_W-1:0] header_fill_q, header_fill_d;
	logic [SIZE_W-1:0]     data_rem_q, data_rem_d;
	logic [HDR_FILL_W-1:0] pad_rem_q, pad_rem_d;
	logic [SIZE_W-1:0]     size_acc_q, size_acc_d;
	size_phase_t           phase_q, phase_d;
	logic                  all_zero_q, all_zero_d;
	logic                  name_ok_q, name_ok_d;
	logic [7:0]            type_q, type_d;
	logic                  entry_open_q, entry_open_d;
	logic                  entry_found_q, entry_found_d;
	logic                  ended_q, ended_d;

	logic                  r_valid, r_last;
	logic [7:0]            r_byte;
	status_t               r_status;

	logic                  m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;

	logic accept;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		logic [7:0]            b;
		logic [HDR_FILL_W-1:0] p;
		logic [HDR_FILL_W-1:0] len_ext;
		logic [7:0]            want;
		b       = s_tdata;
		p       = header_fill_q;
		len_ext = HDR_FILL_W'(name_length_q);
		want    = name_byte_q[p[NAME_LEN_W-1:0]];

		header_fill_d = header_fill_q;
		data_rem_d    = data_rem_q;
		pad_rem_d     = pad_rem_q;
		size_acc_d    = size_acc_q;
		phase_d       = phase_q;
		all_zero_d    = all_zero_q;
		name_ok_d     = name_ok_q;
		type_d        = type_q;
		entry_open_d  = entry_open_q;
		entry_found_d = entry_found_q;
		ended_d       = ended_q;
		r_valid       = 1'b0;
		r_byte        = 8'd0;
		r_last        = 1'b0;
		r_status      = STATUS_NONE;

		if (s_tuser) begin
			if (!entry_found_q)
				r_status = STATUS_NOT_FOUND;
			else if (entry_open_q)
				r_status = STATUS_TRUNCATED;
			else
				r_status = STATUS_COMPLETE;
		end else if (!ended_q) begin
			if (data_rem_q != '0) begin
				data_rem_d = data_rem_q - SIZE_W'(1);
				if (entry_open_q) begin
					r_valid = 1'b1;
					r_byte  = b;
					if (data_rem_d == '0) begin
						r_last       = 1'b1;
						entry_open_d = 1'b0;
					end
				end
			end else if (pad_rem_q != '0) begin
				pad_rem_d = pad_rem_q - HDR_FILL_W'(1);
			end else begin
				if (b != CHAR_NUL)
					all_zero_d = 1'b0;

				if ({1'b0, name_length_q} > MAX_NAME) begin
					name_ok_d = 1'b0;
				end else if (p < len_ext) begin
					if (b == CHAR_NUL || b != want)
						name_ok_d = 1'b0;
				end else if (p == len_ext && p < NAME_FIELD_BYTES) begin
					if (b != CHAR_NUL)
						name_ok_d = 1'b0;
				end

				if (p >= SIZE_OFFSET && p < SIZE_END) begin
					if (phase_d == PHASE_SPACES && b != CHAR_SPACE)
						phase_d = PHASE_DIGITS;
					if (phase_d == PHASE_DIGITS) begin
						if (b >= CHAR_ZERO && b <= CHAR_SEVEN)
							size_acc_d = {size_acc_q[SIZE_W-4:0], b[2:0]};
						else
							phase_d = PHASE_DONE;
					end
				end

				if (p == TYPE_OFFSET)
					type_d = b;

				if (p != BLOCK_LAST) begin
					header_fill_d = p + HDR_FILL_W'(1);
				end else begin
					if (all_zero_d) begin
						ended_d = 1'b1;
					end else begin
						data_rem_d = size_acc_d;
						pad_rem_d  = (~size_acc_d[HDR_FILL_W-1:0]) + HDR_FILL_W'(1);
						if (name_ok_d && (type_d == CHAR_ZERO || type_d == CHAR_NUL)) begin
							entry_found_d = 1'b1;
							entry_open_d  = (size_acc_d != '0);
						end
					end
					// start the next header from scratch
					header_fill_d = '0;
					size_acc_d    = '0;
					phase_d       = PHASE_SPACES;
					all_zero_d    = 1'b1;
					name_ok_d     = 1'b1;
					type_d        = CHAR_NUL;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAME_BYTES; i++)
				name_byte_q[i] <= 8'd0;
			name_length_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_NAME_LENGTH) begin
				name_length_q <= cfg_data[NAME_LEN_W-1:0];
			end else begin
				for (int k = 0; k < 8; k++)
					name_byte_q[{cfg_index, 3'(k)}] <= cfg_data[8*k +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_fill_q <= '0;
			data_rem_q    <= '0;
			pad_rem_q     <= '0;
			size_acc_q    <= '0;
			phase_q       <= PHASE_SPACES;
			all_zero_q    <= 1'b1;
			name_ok_q     <= 1'b1;
			type_q        <= CHAR_NUL;
			entry_open_q  <= 1'b0;
			entry_found_q <= 1'b0;
			ended_q       <= 1'b0;
		end else if (accept) begin
			header_fill_q <= header_fill_d;
			data_rem_q    <= data_rem_d;
			pad_rem_q     <= pad_rem_d;
			size_acc_q    <= size_acc_d;
			phase_q       <= phase_d;
			all_zero_q    <= all_zero_d;
			name_ok_q     <= name_ok_d;
			type_q        <= type_d;
			entry_open_q  <= entry_open_d;
			entry_found_q <= entry_found_d;
			ended_q       <= ended_d;
		end
	end

	// output register: load on every input transfer, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {5'd0, r_status, ended_d, r_byte};
			m_tuser_q <= r_valid;
			m_tlast_q <= r_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_last_has_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("payload_last without payload_valid");

	a_eoi_reports_status: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser |=> m_tvalid && m_tdata[10:9] != STATUS_NONE && !m_tuser)
		else $error("end of input did not report a final status");

	a_open_implies_found: assert property (@(posedge clk) disable iff (!arst_n)
		entry_open_q |-> entry_found_q)
		else $error("entry open but never found");

	a_no_payload_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> !entry_open_q && data_rem_q == '0)
		else $error("data outstanding after archive end");

endmodule
`default_nettype wire
